/* design/lpfd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package lpfd_pkg;
    localparam int BufferBytesDefault = 64;
    localparam int HeaderBytes        = 4;

    localparam logic [1:0] OP_DATA       = 2'd0;
    localparam logic [1:0] OP_CONNECT    = 2'd1;
    localparam logic [1:0] OP_DISCONNECT = 2'd2;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_ACCEPT  = 2'd2;
    localparam logic [1:0] KIND_BUSY    = 2'd3;
endpackage
`default_nettype wire

/* design/length_prefixed_frame_deframer_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Length-prefixed frame deframer. Stream bytes (op 0) land in a circular byte
// memory of BUFFER_BYTES entries addressed by a head pointer and a fill count.
// After each byte the block scans from the head: it reads the four header bytes
// one per cycle from the synchronous memory's read port. A first byte that does
// not match marker_reg, or a frame longer than the buffer, advances the head
// by one byte and the scan retries. An incomplete frame ends the scan and the
// block takes the next beat. A complete frame is delivered as one output beat
// per payload byte (kind 0, with type, length, index and last mark) or a single
// empty-frame beat (kind 1), then the head skips the frame and the scan goes on.
// The final beat of each frame is held until the scan shows whether another
// frame follows, so last marks only the final beat caused by the input beat.
// Compaction is the head move itself, so no bytes are copied. Disconnect and
// an accepted connect empty the buffer; connect reports accepted (kind 2) or
// busy (kind 3). A scan starts in S_CHECK, which stops it when fewer than four
// bytes are buffered; else the header is read in S_H0 to S_H3 and judged in
// S_EVAL. A version mismatch resyncs from S_H0, an oversize length from S_EVAL.
// Each payload beat takes a memory read (S_PREAD), then a send (S_PSEND) that
// waits for the receiver; a held beat goes out when the scan sees what follows.
// The store needs no clearing pass after reset: only entries inside the fill
// count are read.
module length_prefixed_frame_deframer_unit #(
    parameter int BUFFER_BYTES = lpfd_pkg::BufferBytesDefault
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] op,
    input  wire logic [7:0] data_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      result_kind,
    output logic [7:0]      frame_type,
    output logic [5:0]      payload_length,
    output logic [5:0]      payload_index,
    output logic [7:0]      payload_value,
    output logic            last
);
    import lpfd_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam logic [CW-1:0] HDR = CW'(HeaderBytes);
    localparam logic [16:0] MAX_PAYLOAD = 17'(BUFFER_BYTES - HeaderBytes);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_H0, S_H1, S_H2, S_H3, S_EVAL, S_PREAD, S_PSEND, S_ESEND
    } state_t;

    state_t        state_reg;
    logic [7:0]    marker_reg;
    logic [AW-1:0] head_reg;
    logic [CW-1:0] fill_reg;
    logic          session_reg;
    logic [7:0]    mem [BUFFER_BYTES];
    logic [7:0]    rdata_reg;
    logic [7:0]    type_reg;
    logic [7:0]    len_lo_reg;
    logic [5:0]    idx_reg;
    logic [5:0]    len_reg;
    logic          pend_reg;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [AW-1:0] raddr_reg;

    // Wrap an offset from head into the circular store.
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [CW-1:0] b);
        logic [CW:0] s;
        s = (CW+1)'(a) + (CW+1)'(b);
        if (s >= (CW+1)'(BUFFER_BYTES)) s = s - (CW+1)'(BUFFER_BYTES);
        return s[AW-1:0];
    endfunction

    assign in_ready  = (state_reg == S_IDLE);
    assign mem_we    = in_valid && in_ready && (op == OP_DATA);
    assign mem_waddr = wrap_add(head_reg, fill_reg);
    assign mem_raddr = raddr_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we) mem[mem_waddr] <= data_byte;
        rdata_reg <= mem[mem_raddr];
    end

    logic [16:0] hdr_len;
    logic        frame_whole;
    logic        out_free;
    logic        beat_raise;

    assign hdr_len     = {1'b0, rdata_reg, len_lo_reg};
    assign frame_whole = (17'(fill_reg) >= hdr_len + 17'(HeaderBytes));
    assign out_free    = !out_valid || out_ready;

    // Raise the output beat: connect replies, held final beats, payload beats.
    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  beat_raise = in_valid && (op == OP_CONNECT);
            S_CHECK: beat_raise = pend_reg && (fill_reg < HDR);
            S_EVAL:  beat_raise = pend_reg && (hdr_len <= MAX_PAYLOAD);
            S_PSEND: beat_raise = out_free && (idx_reg != len_reg - 6'd1);
            default: beat_raise = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            marker_reg  <= 8'd1;
            head_reg    <= '0;
            fill_reg    <= '0;
            session_reg <= 1'b0;
            out_valid   <= 1'b0;
            raddr_reg   <= '0;
            result_kind <= KIND_PAYLOAD;
            frame_type  <= '0;
            payload_length <= '0;
            payload_index  <= '0;
            payload_value  <= '0;
            last        <= 1'b0;
            type_reg    <= '0;
            len_lo_reg  <= '0;
            idx_reg     <= '0;
            len_reg     <= '0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we) marker_reg <= cfg_wdata;
            if (beat_raise) out_valid <= 1'b1;
            else if (out_ready) out_valid <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        case (op)
                            OP_DATA:
                            begin
                                fill_reg  <= fill_reg + 1'b1;
                                raddr_reg <= head_reg;
                                state_reg <= S_CHECK;
                            end
                            OP_CONNECT:
                            begin
                                result_kind <= session_reg ? KIND_BUSY : KIND_ACCEPT;
                                if (!session_reg) fill_reg <= '0;
                                session_reg <= 1'b1;
                                frame_type <= '0; payload_length <= '0;
                                payload_index <= '0; payload_value <= '0;
                                last <= 1'b1;
                                state_reg <= S_ESEND;
                            end
                            OP_DISCONNECT:
                            begin
                                session_reg <= 1'b0;
                                fill_reg <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_CHECK:
                begin
                    // Need a whole header before reading anything.
                    if (fill_reg >= HDR)
                    begin
                        raddr_reg <= wrap_add(head_reg, CW'(1));
                        state_reg <= S_H0;
                    end
                    else if (pend_reg)
                    begin
                        // Scan over: release the held beat as the last one.
                        last      <= 1'b1;
                        pend_reg  <= 1'b0;
                        state_reg <= S_ESEND;
                    end
                    else state_reg <= S_IDLE;
                end
                S_H0:
                begin
                    // Data for byte 0 is valid now.
                    if (rdata_reg != marker_reg)
                    begin
                        head_reg  <= wrap_add(head_reg, CW'(1));
                        fill_reg  <= fill_reg - 1'b1;
                        raddr_reg <= wrap_add(head_reg, CW'(1));
                        state_reg <= S_CHECK;
                    end
                    else
                    begin
                        raddr_reg <= wrap_add(head_reg, CW'(2));
                        state_reg <= S_H1;
                    end
                end
                S_H1:
                begin
                    type_reg  <= rdata_reg;
                    raddr_reg <= wrap_add(head_reg, CW'(3));
                    state_reg <= S_H2;
                end
                S_H2:
                begin
                    len_lo_reg <= rdata_reg;
                    state_reg  <= S_H3;
                end
                S_H3:
                    state_reg <= S_EVAL;
                S_EVAL:
                begin
                    if (hdr_len > MAX_PAYLOAD)
                    begin
                        head_reg  <= wrap_add(head_reg, CW'(1));
                        fill_reg  <= fill_reg - 1'b1;
                        raddr_reg <= wrap_add(head_reg, CW'(1));
                        state_reg <= S_CHECK;
                    end
                    else if (pend_reg)
                    begin
                        // Release the held beat; it is last unless this frame
                        // completes too.
                        last      <= !frame_whole;
                        pend_reg  <= 1'b0;
                        state_reg <= frame_whole ? S_EVAL : S_ESEND;
                    end
                    else if (!frame_whole)
                        state_reg <= S_IDLE;
                    else if (hdr_len == 17'd0)
                    begin
                        if (out_free)
                        begin
                            result_kind <= KIND_EMPTY;
                            frame_type <= type_reg; payload_length <= '0;
                            payload_index <= '0; payload_value <= '0;
                            last <= 1'b0;
                            pend_reg  <= 1'b1;
                            head_reg  <= wrap_add(head_reg, HDR);
                            fill_reg  <= fill_reg - HDR;
                            raddr_reg <= wrap_add(head_reg, HDR);
                            state_reg <= S_CHECK;
                        end
                    end
                    else
                    begin
                        len_reg   <= hdr_len[5:0];
                        idx_reg   <= '0;
                        raddr_reg <= wrap_add(head_reg, HDR);
                        state_reg <= S_PREAD;
                    end
                end
                S_PREAD:
                    state_reg <= S_PSEND;
                S_PSEND:
                begin
                    if (out_free)
                    begin
                        result_kind <= KIND_PAYLOAD;
                        frame_type <= type_reg;
                        payload_length <= len_reg;
                        payload_index <= idx_reg;
                        payload_value <= rdata_reg;
                        last <= 1'b0;
                        if (idx_reg == len_reg - 6'd1)
                        begin
                            // Frame done: hold its final beat, skip it and
                            // scan on.
                            pend_reg  <= 1'b1;
                            head_reg  <= wrap_add(head_reg, HDR + CW'(len_reg));
                            fill_reg  <= fill_reg - HDR - CW'(len_reg);
                            raddr_reg <= wrap_add(head_reg, HDR + CW'(len_reg));
                            state_reg <= S_CHECK;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 6'd1;
                            raddr_reg <= wrap_add(head_reg, HDR + CW'(idx_reg) + CW'(1));
                            state_reg <= S_PREAD;
                        end
                    end
                end
                S_ESEND:
                begin
                    if (!out_valid || out_ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* tb/sv/length_prefixed_frame_deframer_unit_test.sv */
`timescale 1ns / 1ps
module length_prefixed_frame_deframer_unit_test;
    import lpfd_pkg::*;

    localparam int StoreBytes  = 64;
    localparam int SettleTicks = 400;   // worst resync walk over a full store
    localparam int StallLimit  = 6000;  // cycles with no beat on either side

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ftype;
        logic [5:0] flen;
        logic [5:0] fidx;
        logic [7:0] fval;
        logic       flast;
    } frame_beat_t;

    // Deframer scoreboard: own copy of the store and session, plus the
    // beats still owed by the block.
    class deframe_board;
        logic [7:0]  marker;
        logic [7:0]  store [StoreBytes];
        int          fill;
        bit          session;
        frame_beat_t owed [$];
        int          errors;

        function new();
            marker  = 8'd1;
            fill    = 0;
            session = 0;
            errors  = 0;
        endfunction

        function void push_beat(logic [1:0] k, logic [7:0] t, int l, int i, logic [7:0] v);
            frame_beat_t b;
            b.kind  = k;
            b.ftype = t;
            b.flen  = 6'(l);
            b.fidx  = 6'(i);
            b.fval  = v;
            b.flast = 1'b0;
            owed.push_back(b);
        endfunction

        function void scan_store();
            int off;
            int len;
            int total;
            off = 0;
            while (fill >= off + HeaderBytes) begin
                if (store[off] != marker) begin
                    off++;
                    continue;
                end
                len   = {store[off+3], store[off+2]};
                total = HeaderBytes + len;
                if (total > StoreBytes) begin
                    off++;
                    continue;
                end
                if (fill - off < total)
                    break;
                if (len == 0)
                    push_beat(KIND_EMPTY, store[off+1], 0, 0, 8'd0);
                else
                    for (int i = 0; i < len; i++)
                        push_beat(KIND_PAYLOAD, store[off+1], len, i,
                                  store[off+HeaderBytes+i]);
                off += total;
            end
            if (off > 0) begin
                for (int i = 0; i < fill - off; i++)
                    store[i] = store[i+off];
                fill = fill - off;
            end
        endfunction

        function void note_input(logic [1:0] op_c, logic [7:0] b);
            int owed_before;
            owed_before = owed.size();
            if (op_c == OP_DATA) begin
                if (fill >= StoreBytes) begin
                    for (int i = 0; i < StoreBytes - 1; i++)
                        store[i] = store[i+1];
                    fill = StoreBytes - 1;
                end
                store[fill] = b;
                fill++;
                scan_store();
            end else if (op_c == OP_CONNECT) begin
                if (session)
                    push_beat(KIND_BUSY, 8'd0, 0, 0, 8'd0);
                else begin
                    session = 1;
                    fill    = 0;
                    push_beat(KIND_ACCEPT, 8'd0, 0, 0, 8'd0);
                end
            end else if (op_c == OP_DISCONNECT) begin
                session = 0;
                fill    = 0;
            end
            if (owed.size() > owed_before)
                owed[owed.size()-1].flast = 1'b1;
        endfunction

        function void check_result(frame_beat_t got);
            frame_beat_t want;
            if (owed.size() == 0) begin
                $error("unexpected result beat kind %0d", got.kind);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (got.kind !== want.kind) begin
                $error("result_kind exp %0d got %0d", want.kind, got.kind);
                errors++;
            end
            if (got.ftype !== want.ftype) begin
                $error("frame_type exp %0d got %0d", want.ftype, got.ftype);
                errors++;
            end
            if (got.flen !== want.flen) begin
                $error("payload_length exp %0d got %0d", want.flen, got.flen);
                errors++;
            end
            if (got.fidx !== want.fidx) begin
                $error("payload_index exp %0d got %0d", want.fidx, got.fidx);
                errors++;
            end
            if (got.fval !== want.fval) begin
                $error("payload_value exp %0d got %0d", want.fval, got.fval);
                errors++;
            end
            if (got.flast !== want.flast) begin
                $error("last exp %0d got %0d", want.flast, got.flast);
                errors++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [7:0] cfg_wdata = 8'd0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] op = 2'd0;
    logic [7:0] data_byte = 8'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] result_kind;
    logic [7:0] frame_type;
    logic [5:0] payload_length;
    logic [5:0] payload_index;
    logic [7:0] payload_value;
    logic       last;

    deframe_board board = new();
    bit  steady;          // no random gaps on either side while set
    int  hold_request;    // receiver holds off this many cycles at its next beat
    int  stall_ticks = 0;
    int  beats_sent;

    always #5 clk = ~clk;

    length_prefixed_frame_deframer_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_kind   (result_kind),
        .frame_type    (frame_type),
        .payload_length(payload_length),
        .payload_index (payload_index),
        .payload_value (payload_value),
        .last          (last)
    );

    // Abort when neither channel moves a beat for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_ticks <= 0;
        else
            stall_ticks <= stall_ticks + 1;
        if (stall_ticks >= StallLimit)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Offer one input beat; hold valid and payload until it is taken.
    // Valid is lowered here only when a gap precedes the next beat.
    task automatic send_beat(logic [1:0] op_c, logic [7:0] b);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 16);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        op        <= op_c;
        data_byte <= b;
        do @(posedge clk); while (!in_ready);
        board.note_input(op_c, b);
        beats_sent++;
    endtask

    task automatic send_frame(logic [7:0] ver, logic [7:0] ftype, int len);
        send_beat(OP_DATA, ver);
        send_beat(OP_DATA, ftype);
        send_beat(OP_DATA, 8'(len));
        send_beat(OP_DATA, 8'(len >> 8));
        for (int i = 0; i < len; i++)
            send_beat(OP_DATA, 8'($urandom));
    endtask

    // Drop valid, wait for every owed beat, then let any scan in flight settle.
    task automatic drain_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.owed.size() != 0) @(negedge clk);
        repeat (SettleTicks) @(negedge clk);
    endtask

    // Write the marker only while the block is idle.
    task automatic set_marker(logic [7:0] v);
        drain_block();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        board.marker = v;
    endtask

    // Receiver: random gaps per beat, one long hold-off on request.
    initial
    begin
        frame_beat_t got;
        int gap;
        bit hold_used;
        hold_used = 0;
        @(posedge rst_n);
        forever
        begin
            gap = steady ? 0 : $urandom_range(0, 16);
            if (hold_request > 0 && !hold_used)
            begin
                gap = hold_request;
                hold_used = 1;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            got.kind  = result_kind;
            got.ftype = frame_type;
            got.flen  = payload_length;
            got.fidx  = payload_index;
            got.fval  = payload_value;
            got.flast = last;
            board.check_result(got);
            @(negedge clk);
        end
    end

    // Random traffic: mostly well-formed frames, some noise and broken frames.
    task automatic random_traffic(int count);
        int pick;
        int len;
        int stop;
        stop = beats_sent + count;
        while (beats_sent < stop)
        begin
            pick = $urandom_range(0, 99);
            if ((beats_sent % 40) == 0)
                steady = $urandom_range(0, 2) == 0;
            if (pick < 65)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60)
                                                  : $urandom_range(0, 6);
                send_frame(board.marker, 8'($urandom), len);
            end
            else if (pick < 78)
                send_beat(OP_DATA, 8'($urandom));
            else if (pick < 86)
            begin
                // oversize length: the block must resync past it
                send_beat(OP_DATA, board.marker);
                send_beat(OP_DATA, 8'($urandom));
                send_beat(OP_DATA, 8'($urandom_range(61, 255)));
                send_beat(OP_DATA, 8'($urandom));
            end
            else if (pick < 91)
            begin
                // truncated header, the stream continues over it
                send_beat(OP_DATA, board.marker);
                send_beat(OP_DATA, 8'($urandom));
            end
            else if (pick < 95)
                send_beat(OP_CONNECT, 8'($urandom));
            else if (pick < 98)
                send_beat(OP_DISCONNECT, 8'($urandom));
            else
                send_beat(2'd3, 8'($urandom));
        end
    endtask

    initial
    begin
        beats_sent   = 0;
        steady       = 0;
        hold_request = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: session handling, ignored op, data without a session.
        send_frame(8'd1, 8'hA5, 2);
        send_beat(OP_CONNECT, 8'h00);
        send_beat(OP_CONNECT, 8'hFF);
        send_beat(2'd3, 8'hFF);
        send_beat(OP_DATA, 8'h01);
        send_beat(OP_DISCONNECT, 8'h00);
        send_frame(8'd1, 8'h00, 0);
        send_beat(OP_DATA, 8'h00);
        send_beat(OP_DATA, 8'h01);
        send_beat(OP_DATA, 8'hFF);
        send_beat(OP_DATA, 8'h40);
        send_beat(OP_DATA, 8'h00);
        send_frame(8'd1, 8'hFF, 1);
        send_beat(OP_CONNECT, 8'h00);

        // Largest frame while the receiver holds off: the store fills and
        // the input stalls behind it.
        hold_request = 300;
        send_frame(8'd1, 8'h3C, 60);
        random_traffic(50);

        set_marker(8'd0);
        random_traffic(50);
        set_marker(8'd255);
        random_traffic(50);
        set_marker(8'($urandom_range(2, 254)));
        random_traffic(50);

        drain_block();
        if (board.errors == 0 && board.owed.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

/* length_prefixed_frame_deframer_unit.f */
design/lpfd_pkg.sv
design/length_prefixed_frame_deframer_unit.sv
tb/sv/length_prefixed_frame_deframer_unit_test.sv
